### design/aes_pkg.sv
// AES-128 shared types, S-box and round helpers.
package aes_pkg;

    localparam int NumRounds = 10;
    localparam int BlockW    = 128;
    localparam int HalfW     = 64;
    localparam int IdxW      = 1;

    localparam logic [IdxW-1:0] RegKeyHigh = 1'b0;
    localparam logic [IdxW-1:0] RegKeyLow  = 1'b1;

    typedef logic [BlockW-1:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tab[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        case (r)
            4'd1:    return 8'h01;
            4'd2:    return 8'h02;
            4'd3:    return 8'h04;
            4'd4:    return 8'h08;
            4'd5:    return 8'h10;
            4'd6:    return 8'h20;
            4'd7:    return 8'h40;
            4'd8:    return 8'h80;
            4'd9:    return 8'h1b;
            4'd10:   return 8'h36;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n sits at bits 127-8n
    function automatic logic [7:0] byte_at(input t_block b, input int n);
        return b[BlockW-1-8*n -: 8];
    endfunction

endpackage

### design/aes128_block_encrypt_core.sv
// AES-128 encryption top level: key registers, input whitening, chain of ten round cells.
// Pipeline: one input stage, then ten round cells, between start and o_done.
// Throughput: one block per cycle; busy is always low, blocks stream back to back.
// Each round cell carries its block and its own round key, so a key write
// affects only blocks started after it.
// Reset (synchronous, i_rst_n low) clears the key registers and all valid bits.
// The receiver cannot stall: o_done is high for exactly one cycle per block.
module aes128_block_encrypt_core
    import aes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [HalfW-1:0]  i_plain_high,
    input  logic [HalfW-1:0]  i_plain_low,
    output logic              o_done,
    output logic [HalfW-1:0]  o_cipher_high,
    output logic [HalfW-1:0]  o_cipher_low,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IdxW-1:0]   i_cfg_index,
    input  logic [HalfW-1:0]  i_cfg_data
);
    logic [HalfW-1:0] r_key_high, r_key_low;
    // stage 0: AddRoundKey with cipher key
    logic   r_vld0;
    t_block r_state0, r_key0;

    logic   vld  [NumRounds+1];
    t_block st   [NumRounds+1];
    t_block kk   [NumRounds+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_vld0     <= 1'b0;
        end else begin
            r_vld0 <= start;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegKeyHigh: r_key_high <= i_cfg_data;
                    RegKeyLow:  r_key_low  <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
        r_state0 <= {i_plain_high, i_plain_low} ^ {r_key_high, r_key_low};
        r_key0   <= {r_key_high, r_key_low};
    end

    assign vld[0] = r_vld0;
    assign st[0]  = r_state0;
    assign kk[0]  = r_key0;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_round
        aes_round_cell #(
            .RoundIdx (4'(g)),
            .LastRound(g == NumRounds)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (vld[g-1]),
            .i_state(st[g-1]),
            .i_key  (kk[g-1]),
            .o_vld  (vld[g]),
            .o_state(st[g]),
            .o_key  (kk[g])
        );
    end

    assign o_done        = vld[NumRounds];
    assign o_cipher_high = st[NumRounds][BlockW-1:HalfW];
    assign o_cipher_low  = st[NumRounds][HalfW-1:0];
endmodule

### design/aes_round_cell.sv
// One AES round cell: block state and round key registered, next key derived alongside.
module aes_round_cell
    import aes_pkg::*;
#(
    parameter logic [3:0] RoundIdx = 4'd1,
    parameter bit         LastRound = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_block i_state,
    input  t_block i_key,
    output logic   o_vld,
    output t_block o_state,
    output t_block o_key
);
    t_block n_key, n_state, sh;
    t_block r_state, r_key;
    logic   r_vld;
    logic [7:0] a0, a1, a2, a3, al;
    logic [31:0] t;

    always_comb begin
        // key expansion for this round
        t = {sbox(i_key[23:16]) ^ rcon(RoundIdx), sbox(i_key[15:8]),
             sbox(i_key[7:0]), sbox(i_key[31:24])};
        n_key[127:96] = i_key[127:96] ^ t;
        n_key[95:64]  = i_key[95:64]  ^ n_key[127:96];
        n_key[63:32]  = i_key[63:32]  ^ n_key[95:64];
        n_key[31:0]   = i_key[31:0]   ^ n_key[63:32];
        // SubBytes and ShiftRows
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sh[BlockW-1-8*(r+4*c) -: 8] = sbox(byte_at(i_state, r + 4*((c+r) & 3)));
            end
        end
        n_state = sh;
        a0 = '0; a1 = '0; a2 = '0; a3 = '0; al = '0;
        if (!LastRound) begin
            for (int c = 0; c < 4; c++) begin
                a0 = byte_at(sh, 4*c);
                a1 = byte_at(sh, 4*c+1);
                a2 = byte_at(sh, 4*c+2);
                a3 = byte_at(sh, 4*c+3);
                al = a0 ^ a1 ^ a2 ^ a3;
                n_state[BlockW-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                n_state[BlockW-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                n_state[BlockW-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                n_state[BlockW-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        n_state = n_state ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_state <= n_state;
        r_key   <= n_key;
    end

    assign o_vld   = r_vld;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule

### tb/tb_aes128_block_encrypt_core.sv
// Self-checking testbench for the AES-128 block encryption core.
module tb_aes128_block_encrypt_core;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Reset holds for this many cycles; settle allows for the pipeline depth.
    localparam int ResetCycles = 3;
    localparam int SettleCycles = 20;
    localparam longint CycleLimit = 400000;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [HalfW-1:0] i_plain_high;
    logic [HalfW-1:0] i_plain_low;
    logic             o_done;
    logic [HalfW-1:0] o_cipher_high;
    logic [HalfW-1:0] o_cipher_low;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IdxW-1:0]  i_cfg_index;
    logic [HalfW-1:0] i_cfg_data;

    typedef struct packed {
        logic [HalfW-1:0] hi;
        logic [HalfW-1:0] lo;
    } t_half_pair;

    aes128_block_encrypt_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_plain_high  (i_plain_high),
        .i_plain_low   (i_plain_low),
        .o_done        (o_done),
        .o_cipher_high (o_cipher_high),
        .o_cipher_low  (o_cipher_low),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Key as the testbench believes it is currently held.
    logic [HalfW-1:0] key_hi_model;
    logic [HalfW-1:0] key_lo_model;

    t_half_pair plain_q[$];   // blocks waiting to be driven
    t_half_pair cipher_q[$];  // ciphertexts not yet returned

    int  send_idle_pct;       // sender gap chance in percent
    bit  hold_sender;         // stops the driver entirely
    int  mismatches;
    int  blocks_in;
    int  blocks_out;
    int  key_writes;
    longint cycles;

    // ---------------- AES prediction ----------------
    logic [7:0] sb [256];

    function automatic logic [7:0] gmul2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypt one block under the modelled key.
    function automatic t_half_pair aes_encrypt(input t_half_pair pt);
        logic [7:0] ks [176];
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] w [4];
        logic [7:0] x, a0, a1, a2, a3, all;
        logic [7:0] rc;
        t_half_pair ct;
        for (int n = 0; n < 8; n++) begin
            ks[n]     = key_hi_model[63-8*n -: 8];
            ks[8+n]   = key_lo_model[63-8*n -: 8];
            st[n]     = pt.hi[63-8*n -: 8];
            st[8+n]   = pt.lo[63-8*n -: 8];
        end
        rc = 8'h01;
        for (int p = 16; p < 176; p += 4) begin
            for (int k = 0; k < 4; k++) w[k] = ks[p-4+k];
            if (p % 16 == 0) begin
                x = w[0];
                w[0] = sb[w[1]] ^ rc;
                w[1] = sb[w[2]];
                w[2] = sb[w[3]];
                w[3] = sb[x];
                rc = gmul2(rc);
            end
            for (int k = 0; k < 4; k++) ks[p+k] = ks[p-16+k] ^ w[k];
        end
        for (int n = 0; n < 16; n++) st[n] ^= ks[n];
        for (int r = 1; r <= 10; r++) begin
            // SubBytes with ShiftRows folded in
            for (int c = 0; c < 4; c++)
                for (int rw = 0; rw < 4; rw++)
                    tmp[rw+4*c] = sb[st[rw+4*((c+rw)%4)]];
            st = tmp;
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                    st[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                    st[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                    st[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++) st[n] ^= ks[16*r+n];
        end
        for (int n = 0; n < 8; n++) begin
            ct.hi[63-8*n -: 8] = st[n];
            ct.lo[63-8*n -: 8] = st[8+n];
        end
        return ct;
    endfunction

    // ---------------- clock and cycle limit ----------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d blocks outstanding",
                     cycles, cipher_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- driver ----------------
    // A beat is taken at the rising edge with start high and busy low; the
    // driver looks at that edge's outcome and sets up the next beat on the
    // falling edge, so each signal gets one assignment per step.
    bit beat_taken;
    always @(posedge i_clk) beat_taken <= start && !busy && i_rst_n;

    always @(negedge i_clk) begin
        t_half_pair nxt;
        if (i_rst_n) begin
            if (beat_taken) begin
                cipher_q.push_back(aes_encrypt({i_plain_high, i_plain_low}));
                blocks_in++;
                void'(plain_q.pop_front());
            end
            if (beat_taken && start && !busy) begin
                // beat just consumed; the queue head moved on
            end
            if (!hold_sender && plain_q.size() > 0
                && $urandom_range(99, 0) >= send_idle_pct) begin
                nxt = plain_q[0];
                start        <= 1'b1;
                i_plain_high <= nxt.hi;
                i_plain_low  <= nxt.lo;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_half_pair want;
        if (i_rst_n && o_done) begin
            blocks_out++;
            if (cipher_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected ciphertext %h_%h", o_cipher_high, o_cipher_low);
            end else begin
                want = cipher_q.pop_front();
                if (o_cipher_high !== want.hi || o_cipher_low !== want.lo) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ciphertext mismatch: want %h_%h got %h_%h",
                                 want.hi, want.lo, o_cipher_high, o_cipher_low);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic wait_drained();
        // sender stopped; every block is launched, then every result back
        while (plain_q.size() > 0 || start || beat_taken) @(posedge i_clk);
        while (cipher_q.size() > 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [IdxW-1:0] idx, input logic [HalfW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == RegKeyHigh) key_hi_model = val;
        else                   key_lo_model = val;
        key_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Key change only with the pipeline empty.
    task automatic set_key(input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo);
        wait_drained();
        write_key(RegKeyHigh, hi);
        write_key(RegKeyLow, lo);
    endtask

    function automatic logic [HalfW-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_block(input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo);
        t_half_pair b;
        b.hi = hi;
        b.lo = lo;
        plain_q.push_back(b);
    endtask

    task automatic random_phase(input int count);
        logic [HalfW-1:0] a, b;
        for (int k = 0; k < count; k++) begin
            a = rand64();
            b = rand64();
            // sparse and dense patterns now and then
            case ($urandom_range(7, 0))
                0: a = '0;
                1: b = '1;
                2: a = a & rand64() & rand64();
                default: ;
            endcase
            queue_block(a, b);
        end
    endtask

    initial begin
        foreach (sb[n]) sb[n] = sbox(n[7:0]);
        cycles = 0; mismatches = 0; blocks_in = 0; blocks_out = 0; key_writes = 0;
        key_hi_model = '0;
        key_lo_model = '0;
        hold_sender = 1'b1;
        send_idle_pct = 19;
        start = 1'b0;
        i_plain_high = '0;
        i_plain_low = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = RegKeyHigh;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset key of zero, then the FIPS-197 example key and
        // extreme keys, with extreme and walking-bit plaintexts.
        hold_sender = 1'b0;
        queue_block('0, '0);
        queue_block('1, '1);
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        queue_block('0, '0);
        queue_block('1, '1);
        queue_block(64'h8000000000000000, 64'h0000000000000001);
        queue_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        set_key('1, '1);
        queue_block('0, '0);
        queue_block('1, '1);
        queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        queue_block(64'h0000000000000001, 64'h8000000000000000);

        // Sender pause: let the queue empty, wait for every result, then
        // keep the sender quiet a while longer before carrying on.
        wait_drained();
        hold_sender = 1'b1;
        repeat (SettleCycles) @(posedge i_clk);
        hold_sender = 1'b0;

        // Random: sender gaps 19 %, then 78 %, then back to back, key
        // changes between phases.
        set_key(rand64(), rand64());
        send_idle_pct = 19;
        random_phase(170);
        set_key('0, rand64());
        send_idle_pct = 78;
        random_phase(160);
        set_key(rand64(), '1);
        send_idle_pct = 0;
        random_phase(170);
        wait_drained();

        $display("%0d blocks encrypted, %0d results checked, %0d key register writes",
                 blocks_in, blocks_out, key_writes);
        $display("covered extreme keys and blocks, the standard example vectors and random traffic");
        if (mismatches == 0 && cipher_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, cipher_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
